// ===== sv/prc_pkg.sv =====
// ============================================================================
// prc_pkg
// Shared widths, register indexes, datapath operation codes and the command
// and status types that join the controller to the datapath.
// ============================================================================
package prc_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int MAX_HARMONICS = 4;

    // Field and register widths.
    localparam int ERR_W   = SAMPLE_BITS + 1;
    localparam int DIFF_W  = SAMPLE_BITS + 2;
    localparam int DZ_W    = 16;
    localparam int GAIN_W  = 32;
    localparam int HC_W    = 3;
    localparam int COEF_W  = 32;
    localparam int HIST_W  = 48;
    localparam int DRIVE_W = 32;

    localparam int RES_W = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
    localparam int ACT_W = $clog2(MAX_HARMONICS + 1);

    // Shared multiplier: a coefficient times half of a history word or an error.
    localparam int LO_W    = HIST_W / 2;
    localparam int MUL_A_W = COEF_W;
    localparam int MUL_B_W = (DIFF_W > LO_W + 1) ? DIFF_W : LO_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Fraction alignment of the resonator terms.
    localparam int B0_SHIFT = 12;
    localparam int A1_SHIFT = 30;
    localparam int T1_W     = PROD_W - B0_SHIFT;
    localparam int WIDE_W   = PROD_W + LO_W + 1;
    localparam int M_W      = WIDE_W - A1_SHIFT;
    localparam int Y_W      = M_W + 2;
    localparam int ACC_W    = PROD_W + RES_W + 1;

    // Configuration port.
    localparam int REG_DEAD_ZONE  = 0;
    localparam int REG_PROP_GAIN  = 1;
    localparam int REG_HARM_COUNT = 2;
    localparam int REG_COEFF_BASE = 3;
    localparam int CFG_IDX_W      = $clog2(REG_COEFF_BASE + MAX_HARMONICS + 1);
    localparam int CFG_DATA_W     = 2 * COEF_W;

    // Datapath operations.
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NOP   = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 4'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 4'd2;
    localparam logic [OP_W-1:0] OP_PMUL  = 4'd3;
    localparam logic [OP_W-1:0] OP_PACC  = 4'd4;
    localparam logic [OP_W-1:0] OP_B0    = 4'd5;
    localparam logic [OP_W-1:0] OP_HI    = 4'd6;
    localparam logic [OP_W-1:0] OP_LO    = 4'd7;
    localparam logic [OP_W-1:0] OP_MRG   = 4'd8;
    localparam logic [OP_W-1:0] OP_UPD   = 4'd9;
    localparam logic [OP_W-1:0] OP_OUT   = 4'd10;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [RES_W-1:0] res;
    } prc_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] active;
    } prc_status_t;

endpackage

// ===== sv/prc_if.sv =====
// ============================================================================
// prc_if
// Valid/ready channels of the controller: sample requests, results and
// configuration writes.
// ============================================================================
interface prc_sample_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    action;
    logic signed [prc_pkg::SAMPLE_BITS-1:0] target;
    logic signed [prc_pkg::SAMPLE_BITS-1:0] measure;

    modport source (output valid, action, target, measure, input ready);
    modport sink   (input valid, action, target, measure, output ready);
endinterface

interface prc_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [prc_pkg::DRIVE_W-1:0] drive;

    modport source (output valid, drive, input ready);
    modport sink   (input valid, drive, output ready);
endinterface

interface prc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [prc_pkg::CFG_IDX_W-1:0]      index;
    logic [prc_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/proportional_resonant_controller.sv =====
// ============================================================================
// proportional_resonant_controller
// Proportional gain plus up to four resonant biquads on the tracking error.
// ============================================================================
//
// The block takes sample requests on the sample channel (action, target,
// measure) and returns one drive value on the result channel for every
// compute request. A clear request (action high) zeroes all resonator
// histories in the cycle it is accepted and returns no result.
// Configuration writes arrive on the cfg channel, which is always ready;
// software must write it only while no request is in flight; the block
// itself does not enforce this. Writing a resonator's coefficient
// register also zeroes that resonator's histories.
//
// The steps of a compute request are set by the single 32 x 25 signed
// multiplier, which serves the proportional term and then takes each of
// the N active resonators (0 to 4) through five steps: b0 term, high and
// low halves of the a1 product, their merge, and the history update with
// saturation. The next request is taken in the cycle after the result is
// loaded, while a clear request leaves the block idle and ready.
//
// The result sits in an output register. If the receiver stalls, the block
// still accepts and computes the next request, then waits with that finished
// value until the held result is taken. Reset clears all configuration
// registers and histories and drops result valid.
//
module proportional_resonant_controller (
    input  logic          clk,
    input  logic          rst_n,
    prc_cfg_if.sink       cfg,
    prc_sample_if.sink    sample,
    prc_result_if.source  result
);

    prc_pkg::prc_cmd_t    cmd;
    prc_pkg::prc_status_t status;

    // Configuration registers take a write in any cycle.
    assign cfg.ready = 1'b1;

    // Sequencer: request/result handshakes; one step per cycle unless stalled.
    prc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_action (sample.action),
        .in_ready  (sample.ready),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: registers, histories, shared multiplier and accumulator.
    prc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .target    (sample.target),
        .measure   (sample.measure),
        .drive     (result.drive)
    );

endmodule

// ===== sv/prc_ctrl.sv =====
// ============================================================================
// prc_ctrl
// Sequencer that steps the shared multiplier through the proportional term
// and each active resonator, and owns the request and result handshakes.
// ============================================================================
module prc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_action,
    output logic                  in_ready,
    input  logic                  out_ready,
    output logic                  out_valid,
    input  prc_pkg::prc_status_t  status,
    output prc_pkg::prc_cmd_t     cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PMUL = 4'd1;
    localparam logic [3:0] ST_PACC = 4'd2;
    localparam logic [3:0] ST_B0   = 4'd3;
    localparam logic [3:0] ST_HI   = 4'd4;
    localparam logic [3:0] ST_LO   = 4'd5;
    localparam logic [3:0] ST_MRG  = 4'd6;
    localparam logic [3:0] ST_UPD  = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    logic [3:0]                state_reg;
    logic [3:0]                state_next;
    logic [prc_pkg::RES_W-1:0] res_reg;
    logic [prc_pkg::RES_W-1:0] res_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      last_res;

    assign last_res  = (int'(res_reg) + 1 >= int'(status.active));
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd.op         = prc_pkg::OP_NOP;
        cmd.res        = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_action)
                    begin
                        cmd.op = prc_pkg::OP_CLEAR;
                    end
                    else
                    begin
                        cmd.op     = prc_pkg::OP_LOAD;
                        state_next = ST_PMUL;
                    end
                end
            end
            ST_PMUL:
            begin
                cmd.op     = prc_pkg::OP_PMUL;
                state_next = ST_PACC;
            end
            ST_PACC:
            begin
                cmd.op     = prc_pkg::OP_PACC;
                res_next   = '0;
                state_next = (status.active == '0) ? ST_OUT : ST_B0;
            end
            ST_B0:
            begin
                cmd.op     = prc_pkg::OP_B0;
                state_next = ST_HI;
            end
            ST_HI:
            begin
                cmd.op     = prc_pkg::OP_HI;
                state_next = ST_LO;
            end
            ST_LO:
            begin
                cmd.op     = prc_pkg::OP_LO;
                state_next = ST_MRG;
            end
            ST_MRG:
            begin
                cmd.op     = prc_pkg::OP_MRG;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.op = prc_pkg::OP_UPD;
                if (last_res)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    res_next   = prc_pkg::RES_W'(res_reg + 1'b1);
                    state_next = ST_B0;
                end
            end
            ST_OUT:
            begin
                // The result register is loaded only once the previous result has left.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = prc_pkg::OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/prc_dp.sv =====
// ============================================================================
// prc_dp
// Datapath: configuration registers, resonator histories, one shared
// 32 x 25 signed multiplier and the accumulator with output saturation.
// ============================================================================
module prc_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  prc_pkg::prc_cmd_t                      cmd,
    output prc_pkg::prc_status_t                   status,
    input  logic                                   cfg_we,
    input  logic [prc_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [prc_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic signed [prc_pkg::SAMPLE_BITS-1:0] target,
    input  logic signed [prc_pkg::SAMPLE_BITS-1:0] measure,
    output logic signed [prc_pkg::DRIVE_W-1:0]     drive
);

    localparam logic signed [prc_pkg::Y_W-1:0] Y_MAX =
        prc_pkg::Y_W'({1'b0, {(prc_pkg::HIST_W-1){1'b1}}});
    localparam logic signed [prc_pkg::Y_W-1:0] Y_MIN = -Y_MAX - 1;
    localparam logic signed [prc_pkg::ACC_W-1:0] D_MAX =
        prc_pkg::ACC_W'({1'b0, {(prc_pkg::DRIVE_W-1){1'b1}}});
    localparam logic signed [prc_pkg::ACC_W-1:0] D_MIN = -D_MAX - 1;

    // Configuration registers.
    logic [prc_pkg::DZ_W-1:0]          dead_zone_reg;
    logic signed [prc_pkg::GAIN_W-1:0] prop_gain_reg;
    logic [prc_pkg::HC_W-1:0]          harm_count_reg;
    logic signed [prc_pkg::COEF_W-1:0] b0_reg [prc_pkg::MAX_HARMONICS];
    logic signed [prc_pkg::COEF_W-1:0] a1_reg [prc_pkg::MAX_HARMONICS];

    // Resonator histories.
    logic signed [prc_pkg::ERR_W-1:0]  e1_reg [prc_pkg::MAX_HARMONICS];
    logic signed [prc_pkg::ERR_W-1:0]  e2_reg [prc_pkg::MAX_HARMONICS];
    logic signed [prc_pkg::HIST_W-1:0] y1_reg [prc_pkg::MAX_HARMONICS];
    logic signed [prc_pkg::HIST_W-1:0] y2_reg [prc_pkg::MAX_HARMONICS];

    // Working registers of one sample.
    logic signed [prc_pkg::ERR_W-1:0]   err_reg;
    logic signed [prc_pkg::PROD_W-1:0]  prod_reg;
    logic signed [prc_pkg::T1_W-1:0]    t1_reg;
    logic signed [prc_pkg::PROD_W-1:0]  ahi_reg;
    logic signed [prc_pkg::M_W-1:0]     m_reg;
    logic signed [prc_pkg::ACC_W-1:0]   acc_reg;
    logic signed [prc_pkg::DRIVE_W-1:0] drive_reg;

    logic signed [prc_pkg::ERR_W-1:0]   err_raw;
    logic [prc_pkg::ERR_W-1:0]          err_mag;
    logic signed [prc_pkg::ERR_W-1:0]   err_next;
    logic signed [prc_pkg::DIFF_W-1:0]  diff;
    logic signed [prc_pkg::MUL_A_W-1:0] mul_a;
    logic signed [prc_pkg::MUL_B_W-1:0] mul_b;
    logic signed [prc_pkg::WIDE_W-1:0]  merged;
    logic signed [prc_pkg::Y_W-1:0]     y_sum;
    logic signed [prc_pkg::HIST_W-1:0]  y_sat;
    logic signed [prc_pkg::DRIVE_W-1:0] drive_sat;

    // Harmonic counts above the number of resonators clamp to that number.
    always_comb
    begin
        if (int'(harm_count_reg) > prc_pkg::MAX_HARMONICS)
        begin
            status.active = prc_pkg::ACT_W'(prc_pkg::MAX_HARMONICS);
        end
        else
        begin
            status.active = prc_pkg::ACT_W'(harm_count_reg);
        end
    end

    // Error with dead zone.
    always_comb
    begin
        err_raw = prc_pkg::ERR_W'(target) - prc_pkg::ERR_W'(measure);
        err_mag = err_raw[prc_pkg::ERR_W-1] ? prc_pkg::ERR_W'(-err_raw)
                                             : prc_pkg::ERR_W'(err_raw);
        if ((dead_zone_reg != '0) && (32'(err_mag) < 32'(dead_zone_reg)))
        begin
            err_next = '0;
        end
        else
        begin
            err_next = err_raw;
        end
    end

    assign diff = prc_pkg::DIFF_W'(err_reg) - prc_pkg::DIFF_W'(e2_reg[cmd.res]);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = prop_gain_reg;
        mul_b = prc_pkg::MUL_B_W'(err_reg);
        unique case (cmd.op)
            prc_pkg::OP_B0:
            begin
                mul_a = b0_reg[cmd.res];
                mul_b = prc_pkg::MUL_B_W'(diff);
            end
            prc_pkg::OP_HI:
            begin
                mul_a = a1_reg[cmd.res];
                mul_b = prc_pkg::MUL_B_W'(
                    $signed(y1_reg[cmd.res][prc_pkg::HIST_W-1:prc_pkg::LO_W]));
            end
            prc_pkg::OP_LO:
            begin
                mul_a = a1_reg[cmd.res];
                mul_b = prc_pkg::MUL_B_W'({1'b0, y1_reg[cmd.res][prc_pkg::LO_W-1:0]});
            end
            default:
            begin
                mul_a = prop_gain_reg;
                mul_b = prc_pkg::MUL_B_W'(err_reg);
            end
        endcase
    end

    // a1 * y1 rebuilt from its two partial products, then floored by 2^30.
    assign merged = (prc_pkg::WIDE_W'(ahi_reg) <<< prc_pkg::LO_W) + prc_pkg::WIDE_W'(prod_reg);

    assign y_sum = prc_pkg::Y_W'(t1_reg) - prc_pkg::Y_W'(m_reg)
                 - prc_pkg::Y_W'(y2_reg[cmd.res]);

    always_comb
    begin
        if (y_sum > Y_MAX)
        begin
            y_sat = prc_pkg::HIST_W'(Y_MAX);
        end
        else if (y_sum < Y_MIN)
        begin
            y_sat = prc_pkg::HIST_W'(Y_MIN);
        end
        else
        begin
            y_sat = prc_pkg::HIST_W'(y_sum);
        end

        if (acc_reg > D_MAX)
        begin
            drive_sat = prc_pkg::DRIVE_W'(D_MAX);
        end
        else if (acc_reg < D_MIN)
        begin
            drive_sat = prc_pkg::DRIVE_W'(D_MIN);
        end
        else
        begin
            drive_sat = prc_pkg::DRIVE_W'(acc_reg);
        end
    end

    // Working registers carry no reset.
    always_ff @(posedge clk)
    begin
        prod_reg <= prc_pkg::PROD_W'(mul_a * mul_b);
        case (cmd.op)
            prc_pkg::OP_LOAD: err_reg   <= err_next;
            prc_pkg::OP_PACC: acc_reg   <= prc_pkg::ACC_W'(prod_reg);
            prc_pkg::OP_HI:   t1_reg    <= prc_pkg::T1_W'(prod_reg >>> prc_pkg::B0_SHIFT);
            prc_pkg::OP_LO:   ahi_reg   <= prod_reg;
            prc_pkg::OP_MRG:  m_reg     <= prc_pkg::M_W'(merged >>> prc_pkg::A1_SHIFT);
            prc_pkg::OP_UPD:  acc_reg   <= acc_reg + prc_pkg::ACC_W'(y_sat);
            prc_pkg::OP_OUT:  drive_reg <= drive_sat;
            default:
            begin
            end
        endcase
    end

    // Configuration and history state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg  <= '0;
            prop_gain_reg  <= '0;
            harm_count_reg <= '0;
            for (int k = 0; k < prc_pkg::MAX_HARMONICS; k++)
            begin
                b0_reg[k] <= '0;
                a1_reg[k] <= '0;
                e1_reg[k] <= '0;
                e2_reg[k] <= '0;
                y1_reg[k] <= '0;
                y2_reg[k] <= '0;
            end
        end
        else
        begin
            if (cmd.op == prc_pkg::OP_UPD)
            begin
                e2_reg[cmd.res] <= e1_reg[cmd.res];
                e1_reg[cmd.res] <= err_reg;
                y2_reg[cmd.res] <= y1_reg[cmd.res];
                y1_reg[cmd.res] <= y_sat;
            end

            if (cmd.op == prc_pkg::OP_CLEAR)
            begin
                for (int k = 0; k < prc_pkg::MAX_HARMONICS; k++)
                begin
                    e1_reg[k] <= '0;
                    e2_reg[k] <= '0;
                    y1_reg[k] <= '0;
                    y2_reg[k] <= '0;
                end
            end

            if (cfg_we)
            begin
                if (int'(cfg_index) == prc_pkg::REG_DEAD_ZONE)
                begin
                    dead_zone_reg <= cfg_data[prc_pkg::DZ_W-1:0];
                end
                if (int'(cfg_index) == prc_pkg::REG_PROP_GAIN)
                begin
                    prop_gain_reg <= $signed(cfg_data[prc_pkg::GAIN_W-1:0]);
                end
                if (int'(cfg_index) == prc_pkg::REG_HARM_COUNT)
                begin
                    harm_count_reg <= cfg_data[prc_pkg::HC_W-1:0];
                end
                // A coefficient write also restarts that resonator from rest.
                for (int k = 0; k < prc_pkg::MAX_HARMONICS; k++)
                begin
                    if (int'(cfg_index) == prc_pkg::REG_COEFF_BASE + k)
                    begin
                        b0_reg[k] <= $signed(cfg_data[prc_pkg::CFG_DATA_W-1:prc_pkg::COEF_W]);
                        a1_reg[k] <= $signed(cfg_data[prc_pkg::COEF_W-1:0]);
                        e1_reg[k] <= '0;
                        e2_reg[k] <= '0;
                        y1_reg[k] <= '0;
                        y2_reg[k] <= '0;
                    end
                end
            end
        end
    end

    assign drive = drive_reg;

endmodule

// ===== sv/prc_checker.sv =====
// ============================================================================
// prc_checker
// Port-level checks of the controller's request and result channels.
// ============================================================================
module prc_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                sample_valid,
    input logic                                sample_ready,
    input logic                                sample_action,
    input logic                                result_valid,
    input logic                                result_ready,
    input logic signed [prc_pkg::DRIVE_W-1:0] result_drive
);

    // A result that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result valid dropped while stalled");

    // A result that is not taken keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_drive))
        else $error("result drive changed while stalled");

    // A compute request leaves the block busy, so the next request has to wait.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready && !sample_action |=> !sample_ready)
        else $error("request accepted during a running computation");

    // A clear request completes at once and leaves the block free.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready && sample_action |=> sample_ready)
        else $error("clear request did not complete in one cycle");

    // A result never appears the cycle after a compute request.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready && !sample_action |=> !$rose(result_valid))
        else $error("result appeared before the computation could finish");

endmodule

bind proportional_resonant_controller prc_checker u_prc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .sample_valid  (sample.valid),
    .sample_ready  (sample.ready),
    .sample_action (sample.action),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .result_drive  (result.drive)
);
